>>> rtl/core/stpq_pkg.sv
// ----------------------------------------------------------------------------
// stpq_pkg
// types and codes shared by the sorted time priority queue core and its cells
// ----------------------------------------------------------------------------
package stpq_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_POP    = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] key_time;
    logic [15:0] entry_id;
    logic [15:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic [15:0] head_key;
    logic [15:0] head_ident;
    logic        due;
    logic [4:0]  fill;
    logic [1:0]  error;
  } res_t;

  typedef struct packed {
    logic insert_en;
    logic pop_en;
  } cell_ctrl_t;

endpackage

>>> rtl/core/sorted_time_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_time_priority_queue_core
// bounded queue of (key, id) entries kept in ascending key order in a chain
// of cells; insert, due query and pop, one result per command
// ----------------------------------------------------------------------------
//  channel   dir   payload   handshake
//  cmd       in    cmd_t     cmd_valid / cmd_stall
//  res       out   res_t     res_valid / res_stall
//
//  one command per cycle when cmd_stall is low; its result appears in the
//  output register on the next cycle, set by the single compare-and-shift
//  step of the cell chain; rst clears the occupancy count and the output
//  valid; cells hold no reset; cmd_stall is high while a result waits in
//  the output register and res_stall is high
// ----------------------------------------------------------------------------
module sorted_time_priority_queue_core #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  stpq_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output stpq_pkg::res_t  res
);
  import stpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (KEY_WIDTH > 16) ? KEY_WIDTH : 16;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 is_insert;
  logic                 is_pop;
  logic [KEY_WIDTH-1:0] new_key;
  cell_ctrl_t           ctrl;
  res_t                 res_next;
  logic [KEY_WIDTH-1:0] after_key;
  logic [KEY_WIDTH-1:0] show_key;
  logic [15:0]          show_ident;

  logic [KEY_WIDTH-1:0] cell_key   [DEPTH];
  logic [15:0]          cell_ident [DEPTH];
  logic [DEPTH-1:0]     cell_place;

  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign is_insert = (cmd.action == ACT_INSERT);
  assign is_pop    = (cmd.action == ACT_POP);
  assign new_key   = KEY_WIDTH'(cmd.key_time);

  assign ctrl.insert_en = accept && is_insert && !full;
  assign ctrl.pop_en    = accept && is_pop && !empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_WIDTH-1:0] l_key;
      logic [15:0]          l_ident;
      logic                 l_place;
      logic [KEY_WIDTH-1:0] r_key;
      logic [15:0]          r_ident;
      if (g == 0) begin : g_head
        assign l_key   = cell_key[g];
        assign l_ident = cell_ident[g];
        assign l_place = 1'b0;
      end else begin : g_mid
        assign l_key   = cell_key[g-1];
        assign l_ident = cell_ident[g-1];
        assign l_place = cell_place[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign r_key   = cell_key[g];
        assign r_ident = cell_ident[g];
      end else begin : g_body
        assign r_key   = cell_key[g+1];
        assign r_ident = cell_ident[g+1];
      end
      stpq_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W),
        .IDX       (g)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .new_key     (new_key),
        .new_ident   (cmd.entry_id),
        .fill        (count),
        .left_key    (l_key),
        .left_ident  (l_ident),
        .left_place  (l_place),
        .right_key   (r_key),
        .right_ident (r_ident),
        .key         (cell_key[g]),
        .ident       (cell_ident[g]),
        .place       (cell_place[g])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    show_key   = '0;
    show_ident = '0;
    after_key  = cell_key[0];
    res_next.error = ERR_NONE;
    if (is_insert) begin
      if (full) begin
        res_next.error = ERR_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
      if (!full && cell_place[0]) begin
        after_key  = new_key;
        show_key   = new_key;
        show_ident = cmd.entry_id;
      end else if (!empty) begin
        show_key   = cell_key[0];
        show_ident = cell_ident[0];
      end
    end else if (is_pop) begin
      after_key = cell_key[1];
      if (empty) begin
        res_next.error = ERR_EMPTY;
      end else begin
        count_next = count - CNT_W'(1);
        show_key   = cell_key[0];
        show_ident = cell_ident[0];
      end
    end else if (!empty) begin
      show_key   = cell_key[0];
      show_ident = cell_ident[0];
    end
    res_next.head_key   = 16'(show_key);
    res_next.head_ident = show_ident;
    res_next.fill       = 5'(count_next);
    res_next.due        = (count_next != '0) && (CW'(after_key) <= CW'(cmd.now_time));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_full_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.error == ERR_FULL) |-> full)
    else $error("full refusal while not full");

  a_fill_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.fill == 5'(count)))
    else $error("reported fill differs from occupancy");

  a_empty_not_due: assert property (@(posedge clk) disable iff (rst)
    res_valid && empty |-> !res.due)
    else $error("due reported on empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
               (count == $past(count) - CNT_W'(1)))
    else $error("occupancy moved by more than one");

endmodule

>>> rtl/core/stpq_cell.sv
// ----------------------------------------------------------------------------
// stpq_cell
// one slot of the sorted chain: holds a key and an id, compares against the
// incoming key and shifts right on insert or left on pop
// ----------------------------------------------------------------------------
module stpq_cell #(
  parameter int KEY_WIDTH = 16,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  stpq_pkg::cell_ctrl_t  ctrl,
  input  logic [KEY_WIDTH-1:0]  new_key,
  input  logic [15:0]           new_ident,
  input  logic [CNT_W-1:0]      fill,
  input  logic [KEY_WIDTH-1:0]  left_key,
  input  logic [15:0]           left_ident,
  input  logic                  left_place,
  input  logic [KEY_WIDTH-1:0]  right_key,
  input  logic [15:0]           right_ident,
  output logic [KEY_WIDTH-1:0]  key,
  output logic [15:0]           ident,
  output logic                  place
);
  import stpq_pkg::*;

  logic occupied;

  assign occupied = (CNT_W'(IDX) < fill);
  assign place    = !occupied || (key >= new_key);

  always_ff @(posedge clk) begin
    if (ctrl.insert_en && place) begin
      if (left_place) begin
        key   <= left_key;
        ident <= left_ident;
      end else begin
        key   <= new_key;
        ident <= new_ident;
      end
    end else if (ctrl.pop_en) begin
      key   <= right_key;
      ident <= right_ident;
    end
  end

endmodule

>>> verif/sorted_time_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_time_priority_queue_core_tb
// self-checking testbench for the sorted time priority queue core: a
// scoreboard keeps its own sorted copy of the queue, predicts the status of
// every accepted command and compares it field by field with each result;
// the sender runs in bursts with gaps, the receiver stalls on its own pattern
// ----------------------------------------------------------------------------
module sorted_time_priority_queue_core_tb
  import stpq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 16;
  localparam logic [15:0] KEY_MASK =
    (KEY_WIDTH >= 16) ? 16'hFFFF : 16'((1 << KEY_WIDTH) - 1);
  localparam int RANDOM_COMMANDS = 500;
  localparam int LONG_HOLD       = 80;

  class queue_scoreboard;
    logic [15:0] slot_key [DEPTH];
    logic [15:0] slot_ident [DEPTH];
    int          occ;
    res_t        awaited_status [$];
    int          mismatches;
    int          n_insert, n_query, n_pop, n_other, n_full, n_empty, max_fill;
    int          n_checked;

    function new();
      occ = 0;
      mismatches = 0;
      n_insert = 0; n_query = 0; n_pop = 0; n_other = 0;
      n_full = 0; n_empty = 0; max_fill = 0; n_checked = 0;
    endfunction

    function int pending();
      return awaited_status.size();
    endfunction

    function res_t apply_command(cmd_t c);
      res_t        r;
      logic [15:0] k;
      int          pos;
      int          idx;
      bit          shown;
      r = '0;
      shown = 1'b0;
      k = c.key_time & KEY_MASK;
      case (c.action)
        ACT_INSERT: begin
          n_insert++;
          if (occ >= DEPTH) begin
            r.error = ERR_FULL;
            n_full++;
          end else begin
            pos = 0;
            while (pos < occ && slot_key[pos] < k) pos++;
            for (idx = occ; idx > pos; idx--) begin
              slot_key[idx]   = slot_key[idx-1];
              slot_ident[idx] = slot_ident[idx-1];
            end
            slot_key[pos]   = k;
            slot_ident[pos] = c.entry_id;
            occ++;
          end
        end
        ACT_POP: begin
          n_pop++;
          shown = 1'b1;
          if (occ == 0) begin
            r.error = ERR_EMPTY;
            n_empty++;
          end else begin
            r.head_key   = slot_key[0];
            r.head_ident = slot_ident[0];
            for (idx = 1; idx < occ; idx++) begin
              slot_key[idx-1]   = slot_key[idx];
              slot_ident[idx-1] = slot_ident[idx];
            end
            occ--;
          end
        end
        ACT_QUERY: n_query++;
        default:   n_other++;
      endcase
      if (!shown && occ > 0) begin
        r.head_key   = slot_key[0];
        r.head_ident = slot_ident[0];
      end
      r.due  = (occ > 0) && (slot_key[0] <= c.now_time);
      r.fill = 5'(occ);
      if (occ > max_fill) max_fill = occ;
      return r;
    endfunction

    function void note_command(cmd_t c);
      awaited_status.push_back(apply_command(c));
    endfunction

    function void report(string what, res_t e, res_t a);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch: %s exp key=%h id=%h due=%b fill=%0d err=%0d",
                 $realtime, what, e.head_key, e.head_ident, e.due, e.fill, e.error,
                 " act key=%h id=%h due=%b fill=%0d err=%0d",
                 a.head_key, a.head_ident, a.due, a.fill, a.error);
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (awaited_status.size() == 0) begin
        report("unexpected transaction", '0, a);
        return;
      end
      e = awaited_status.pop_front();
      n_checked++;
      if (a.head_key !== e.head_key || a.head_ident !== e.head_ident ||
          a.due !== e.due || a.fill !== e.fill || a.error !== e.error)
        report("result fields", e, a);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  queue_scoreboard sb = new();

  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int burst_left = 1;

  sorted_time_priority_queue_core #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  // receiver: checks accepted results, stalls on its own pattern
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) sb.check_result(res);
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD - 1;
      res_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (stall_mode)
        0:       res_stall <= 1'b0;
        1:       res_stall <= 1'($urandom_range(0, 1));
        default: res_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] a, logic [15:0] k, logic [15:0] id,
                                    logic [15:0] now);
    cmd_t c;
    c.action   = a;
    c.key_time = k;
    c.entry_id = id;
    c.now_time = now;
    return c;
  endfunction

  function automatic logic [15:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom_range(0, 15));
    if (r < 45) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic cmd_t random_cmd(int mix);
    int   r;
    cmd_t c;
    r = $urandom_range(0, 99);
    c.key_time = pick_time();
    c.entry_id = 16'($urandom);
    c.now_time = pick_time();
    case (mix)
      0:       c.action = (r < 75) ? ACT_INSERT : (r < 85) ? ACT_QUERY :
                          (r < 95) ? ACT_POP : ACT_SPARE;
      1:       c.action = (r < 15) ? ACT_INSERT : (r < 25) ? ACT_QUERY :
                          (r < 95) ? ACT_POP : ACT_SPARE;
      default: c.action = (r < 40) ? ACT_INSERT : (r < 65) ? ACT_QUERY :
                          (r < 95) ? ACT_POP : ACT_SPARE;
    endcase
    return c;
  endfunction

  // one transaction on the command channel, then burst/gap pacing
  task automatic offer(cmd_t c);
    int gap;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    sb.note_command(c);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_queue();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int mix;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, extremes, equal keys, due boundaries, full queue
    offer(make_cmd(ACT_POP,    16'h1234, 16'h5678, 16'hFFFF));
    offer(make_cmd(ACT_QUERY,  16'h0000, 16'h0000, 16'hFFFF));
    offer(make_cmd(ACT_SPARE,  16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer(make_cmd(ACT_INSERT, 16'hFFFF, 16'h0000, 16'h0000));
    offer(make_cmd(ACT_INSERT, 16'h0000, 16'hFFFF, 16'h0000));
    offer(make_cmd(ACT_INSERT, 16'h0000, 16'h1234, 16'hFFFF));
    offer(make_cmd(ACT_QUERY,  16'hAAAA, 16'h5555, 16'h0000));
    offer(make_cmd(ACT_SPARE,  16'h5555, 16'hAAAA, 16'hFFFF));
    offer(make_cmd(ACT_POP,    16'h0000, 16'h0000, 16'h0000));
    offer(make_cmd(ACT_POP,    16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer(make_cmd(ACT_QUERY,  16'h0000, 16'h0000, 16'hFFFE));
    offer(make_cmd(ACT_QUERY,  16'h0000, 16'h0000, 16'hFFFF));
    for (int n = 0; n < 15; n++)
      offer(make_cmd(ACT_INSERT, 16'($urandom_range(0, 7)), 16'($urandom), 16'h0008));
    offer(make_cmd(ACT_INSERT, 16'h0000, 16'hBEEF, 16'hFFFF));
    drain_queue();

    // random: randomly chosen fill, drain and balanced mixes
    mix = 0;
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n % 40 == 0) mix = $urandom_range(0, 2);
      if (n == 150) hold_request = 1'b1;
      if (n == 320) drain_queue();
      offer(random_cmd(mix));
    end

    drain_queue();
    repeat (8) @(posedge clk);
    $display("covered %0d inserts (%0d refused full), %0d pops (%0d refused empty),",
             sb.n_insert, sb.n_full, sb.n_pop, sb.n_empty);
    $display("%0d queries, %0d unused codes, peak fill %0d, %0d results checked",
             sb.n_query, sb.n_other, sb.max_fill, sb.n_checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule
